/* hdl/battery_level_monitor_unit_macros.svh */
// ----------------------------------------------------------------------------
// Battery level monitor assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef BATTERY_LEVEL_MONITOR_UNIT_MACROS_SVH
`define BATTERY_LEVEL_MONITOR_UNIT_MACROS_SVH

// Same-cycle implication
`define BLM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("battery level monitor: same-cycle check failed");

// Next-cycle implication
`define BLM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("battery level monitor: next-cycle check failed");

`endif

/* hdl/blm_pkg.sv */
// ----------------------------------------------------------------------------
// Battery level monitor package
// Field widths, register codes and reset values shared by the monitor.
// ----------------------------------------------------------------------------
package blm_pkg;

  // Field widths
  localparam int unsigned MV_W    = 14;
  localparam int unsigned HYST_W  = 10;
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned LEVEL_W = 3;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned CFG_W   = 16;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned IN_W  = 16;
  localparam int unsigned OUT_W = 24;

  // Threshold registers present
  localparam int unsigned THR_REGS = 4;

  // Parameter defaults
  localparam int unsigned LEVEL_COUNT_DEF   = 4;
  localparam int unsigned FRACTION_BITS_DEF = 8;

  // Register reset values
  localparam logic [THR_REGS-1:0][MV_W-1:0] THR_RESET = {
    14'd3982, 14'd3839, 14'd3646, 14'd3527
  };
  localparam logic [HYST_W-1:0] HYST_RESET  = 10'd10;
  localparam logic [MV_W-1:0]   LOW_RESET   = 14'd3000;
  localparam logic [COEF_W-1:0] COEF_RESET  = 16'd64881;

  // Configuration register codes
  typedef enum logic [IDX_W-1:0] {
    REG_THR_ONE   = 3'd0,
    REG_THR_TWO   = 3'd1,
    REG_THR_THREE = 3'd2,
    REG_THR_FOUR  = 3'd3,
    REG_HYST      = 3'd4,
    REG_LOW_LIMIT = 3'd5,
    REG_COEF      = 3'd6
  } cfg_reg_e;

endpackage

/* hdl/battery_level_monitor_unit.sv */
// ----------------------------------------------------------------------------
// Battery level monitor
// Low-pass filters battery voltage samples, derives a 0..4 level with
// hysteresis, and flags low-battery power-off and USB attach.
// ----------------------------------------------------------------------------
// One input request gives exactly one result through two register stages: an
// input register, then one pass of filter update, threshold compares and flag
// logic into the result register. A new request is taken every cycle unless
// the result stage stalls; filter state, level and USB history are written
// in the same cycle the result is loaded, so the single filter multiply and
// compare path sets the rate. Configuration writes are taken at once.
`include "battery_level_monitor_unit_macros.svh"

module battery_level_monitor_unit
  import blm_pkg::*;
#(
  parameter int unsigned LEVEL_COUNT   = LEVEL_COUNT_DEF,
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  // sample stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // [13:0] sample_mv, [14] usb_powered, [15] already_off
  input  logic [IN_W-1:0]   s_axis_tdata,
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [2:0] battery_level, [16:3] filtered_mv, [17] power_off_request,
  // [18] usb_attach_event, [23:19] zero
  output logic [OUT_W-1:0]  m_axis_tdata
);

  localparam int unsigned FW      = MV_W + FRACTION_BITS;
  localparam int unsigned THR_X_W = MV_W + 1;
  localparam int unsigned NUM_CMP = (LEVEL_COUNT < THR_REGS) ? LEVEL_COUNT : THR_REGS;
  localparam int unsigned PROD_W  = FW + COEF_W + 2;
  localparam int unsigned OUT_PAD = OUT_W - (LEVEL_W + MV_W + 2);

  // Configuration registers
  logic [THR_REGS-1:0][MV_W-1:0] thr_q;
  logic [HYST_W-1:0]             hyst_q;
  logic [MV_W-1:0]               low_q;
  logic [COEF_W-1:0]             coef_q;

  // Monitor state
  logic [FW-1:0]      filt_q;
  logic [LEVEL_W-1:0] level_q;
  logic               usb_seen_q;

  // Input stage
  logic            in_valid_q;
  logic [MV_W-1:0] in_sample_q;
  logic            in_usb_q;
  logic            in_off_q;

  // Result stage
  logic               out_valid_q;
  logic [LEVEL_W-1:0] out_level_q;
  logic [MV_W-1:0]    out_mv_q;
  logic               out_poff_q;
  logic               out_attach_q;

  // Datapath
  logic                  advance;
  logic                  fire;
  logic [FW-1:0]         s_fx;
  logic signed [FW:0]    diff;
  logic signed [COEF_W:0] k_s;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rounded;
  logic signed [PROD_W-1:0] shifted;
  logic [FW-1:0]         filt_d;
  logic [LEVEL_W-1:0]    level_d;
  logic                  low;
  logic                  poff;
  logic                  attach;

  // Handshake: result stage frees when empty or taken
  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THR_RESET;
      hyst_q <= HYST_RESET;
      low_q  <= LOW_RESET;
      coef_q <= COEF_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_THR_ONE:   thr_q[0] <= cfg_data_i[MV_W-1:0];
        REG_THR_TWO:   thr_q[1] <= cfg_data_i[MV_W-1:0];
        REG_THR_THREE: thr_q[2] <= cfg_data_i[MV_W-1:0];
        REG_THR_FOUR:  thr_q[3] <= cfg_data_i[MV_W-1:0];
        REG_HYST:      hyst_q   <= cfg_data_i[HYST_W-1:0];
        REG_LOW_LIMIT: low_q    <= cfg_data_i[MV_W-1:0];
        REG_COEF:      coef_q   <= cfg_data_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Input stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Input stage payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_sample_q <= s_axis_tdata[MV_W-1:0];
      in_usb_q    <= s_axis_tdata[MV_W];
      in_off_q    <= s_axis_tdata[MV_W+1];
    end
  end

  // Filter: f' = s + round(k * (f - s) / 2^16), load sample while unprimed
  always_comb begin
    s_fx    = {in_sample_q, {FRACTION_BITS{1'b0}}};
    diff    = $signed({1'b0, filt_q}) - $signed({1'b0, s_fx});
    k_s     = $signed({1'b0, coef_q});
    prod    = PROD_W'(k_s) * PROD_W'(diff);
    rounded = prod + $signed({{(FW + 2){1'b0}}, 1'b1, {(COEF_W - 1){1'b0}}});
    shifted = rounded >>> COEF_W;
    if (filt_q == '0) begin
      filt_d = s_fx;
    end else begin
      filt_d = s_fx + shifted[FW-1:0];
    end
  end

  // Level: highest threshold met, hysteresis on thresholds at or above level
  always_comb begin
    logic [THR_X_W-1:0] thr_eff;
    level_d = '0;
    thr_eff = '0;
    for (int i = 0; i < NUM_CMP; i++) begin
      thr_eff = {1'b0, thr_q[i]};
      if (LEVEL_W'(i) >= level_q) begin
        thr_eff = thr_eff + {{(THR_X_W - HYST_W){1'b0}}, hyst_q};
      end
      if ({1'b0, filt_d} >= {thr_eff, {FRACTION_BITS{1'b0}}}) begin
        level_d = LEVEL_W'(i + 1);
      end
    end
  end

  // Power-off and attach flags
  assign low    = filt_d < {low_q, {FRACTION_BITS{1'b0}}};
  assign poff   = !in_usb_q && !in_off_q && low;
  assign attach = in_usb_q && !usb_seen_q;

  // Update monitor state on each processed request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q     <= '0;
      level_q    <= '0;
      usb_seen_q <= 1'b0;
    end else if (fire) begin
      filt_q     <= filt_d;
      level_q    <= level_d;
      usb_seen_q <= in_usb_q;
    end
  end

  // Result stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  // Result stage payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_level_q  <= level_d;
      out_mv_q     <= filt_d[FW-1:FRACTION_BITS];
      out_poff_q   <= poff;
      out_attach_q <= attach;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_attach_q, out_poff_q, out_mv_q, out_level_q};

  // Checks
  `BLM_ASSERT_NEXT(a_fire_loads_result, fire, out_valid_q)
  `BLM_ASSERT_NEXT(a_result_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `BLM_ASSERT_NEXT(a_usb_history, fire, usb_seen_q == $past(in_usb_q))
  `BLM_ASSERT_NEXT(a_accept_fills_input, s_axis_tvalid && s_axis_tready, in_valid_q)

endmodule
